>>> hw/rtl/v3n_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_pkg: shared types and constants for the vector normalizer
// Formats, payload structs and the per-cell pipeline records.
// ----------------------------------------------------------------------------
package v3n_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int UNIT_FRAC_BITS  = 14;

  localparam int CW    = COMPONENT_WIDTH;
  localparam int UW    = UNIT_FRAC_BITS + 2;
  // sum of three squares of CW-bit magnitudes
  localparam int SW    = 2 * CW + 2;
  // root of SW bits, plus one for the round-up
  localparam int RW    = SW / 2 + 1;
  localparam int ROOT_STEPS = SW / 2;
  // dividend: magnitude shifted by the fraction bits, plus half divisor
  localparam int NW    = CW + UNIT_FRAC_BITS + 1;
  localparam int QW    = NW;
  localparam int DIV_STEPS = NW;

  typedef struct packed {
    logic signed [CW-1:0] vec_x;
    logic signed [CW-1:0] vec_y;
    logic signed [CW-1:0] vec_z;
  } vec_in_t;

  typedef struct packed {
    logic signed [UW-1:0] unit_x;
    logic signed [UW-1:0] unit_y;
    logic signed [UW-1:0] unit_z;
    logic        [CW-1:0] vec_length;
    logic                 zero_length;
  } vec_out_t;

  // square root cell record; the running root is scaled by the current bit
  typedef struct packed {
    logic          vld;
    logic [SW-1:0] rem;
    logic [SW-1:0] root;
    logic [2:0][CW-1:0] mag;
    logic [2:0]    neg;
    logic          zero;
  } sqrt_rec_t;

  // divider cell record, three lanes sharing one divisor
  typedef struct packed {
    logic          vld;
    logic [RW-1:0] dvs;
    logic [2:0][NW-1:0] rem;
    logic [2:0][NW-1:0] num;
    logic [2:0][QW-1:0] quo;
    logic [2:0]    neg;
    logic [CW-1:0] len;
    logic          zero;
  } div_rec_t;

endpackage : v3n_pkg
`default_nettype wire

>>> hw/rtl/vector3_normalize.sv
`default_nettype none
// Path from start to strobe: input stages, square-root cells, rounding stage, divider cells, output register.
// Throughput: one vector per cycle; busy is always low, tied off in this module.
// The row of square-root cells and the row of divider cells each take one bit per cell.
// Reset (rst, synchronous) clears all valid flags; payload is not reset.
// ----------------------------------------------------------------------------
// vector3_normalize: pipelined 3-vector normalizer
// Squares, integer square root, rounding, then three-lane division.
// ----------------------------------------------------------------------------
module vector3_normalize (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire v3n_pkg::vec_in_t  din,
  output logic                  strobe,
  output v3n_pkg::vec_out_t     dout
);
  import v3n_pkg::*;

  // stage 1: magnitudes
  logic          s1_vld;
  logic [2:0][CW-1:0] s1_mag;
  logic [2:0]    s1_neg;
  // stage 2: squares
  logic          s2_vld;
  logic [2:0][2*CW-1:0] s2_sq;
  logic [2:0][CW-1:0] s2_mag;
  logic [2:0]    s2_neg;

  sqrt_rec_t sq_chain [ROOT_STEPS+1];
  div_rec_t  dv_chain [DIV_STEPS+1];
  logic [SW-1:0] sum;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= start;
      s2_vld <= s1_vld;
    end
    s1_neg <= {din.vec_z[CW-1], din.vec_y[CW-1], din.vec_x[CW-1]};
    s1_mag[0] <= din.vec_x[CW-1] ? CW'(-din.vec_x) : CW'(din.vec_x);
    s1_mag[1] <= din.vec_y[CW-1] ? CW'(-din.vec_y) : CW'(din.vec_y);
    s1_mag[2] <= din.vec_z[CW-1] ? CW'(-din.vec_z) : CW'(din.vec_z);
    for (int i = 0; i < 3; i++) s2_sq[i] <= s1_mag[i] * s1_mag[i];
    s2_mag <= s1_mag;
    s2_neg <= s1_neg;
  end

  // sum of squares feeds the root chain
  assign sum = SW'(s2_sq[0]) + SW'(s2_sq[1]) + SW'(s2_sq[2]);
  always_comb begin
    sq_chain[0].vld  = s2_vld;
    sq_chain[0].rem  = sum;
    sq_chain[0].root = '0;
    sq_chain[0].mag  = s2_mag;
    sq_chain[0].neg  = s2_neg;
    sq_chain[0].zero = (sum == '0);
  end

  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_sqrt
    v3n_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .cell_in(sq_chain[g]),
      .step(6'(g)), .cell_out(sq_chain[g+1])
    );
  end

  // rounding stage: round up when remainder exceeds floor root
  sqrt_rec_t sr;
  logic      r_vld;
  logic [RW-1:0] r_len;
  logic [2:0][CW-1:0] r_mag;
  logic [2:0] r_neg;
  logic      r_zero;
  assign sr = sq_chain[ROOT_STEPS];
  always_ff @(posedge clk) begin
    if (rst) r_vld <= 1'b0;
    else     r_vld <= sr.vld;
    r_len  <= RW'((sr.rem > sr.root) ? sr.root + 1'b1 : sr.root);
    r_mag  <= sr.mag;
    r_neg  <= sr.neg;
    r_zero <= sr.zero;
  end

  // divider chain entry: numerator = mag<<F + divisor/2
  logic [RW-1:0] dvs0;
  assign dvs0 = (r_len == '0) ? RW'(1) : r_len;
  always_comb begin
    dv_chain[0].vld  = r_vld;
    dv_chain[0].dvs  = dvs0;
    dv_chain[0].rem  = '0;
    dv_chain[0].quo  = '0;
    dv_chain[0].neg  = r_neg;
    dv_chain[0].len  = CW'(r_len);
    dv_chain[0].zero = r_zero;
    for (int i = 0; i < 3; i++)
      dv_chain[0].num[i] = (NW'(r_mag[i]) << UNIT_FRAC_BITS) + NW'(dvs0 >> 1);
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    v3n_div_cell u_cell (
      .clk(clk), .rst(rst), .cell_in(dv_chain[g]),
      .step(6'(g)), .cell_out(dv_chain[g+1])
    );
  end

  // output register: apply signs
  div_rec_t dr;
  logic [2:0][UW-1:0] uq;
  assign dr = dv_chain[DIV_STEPS];
  always_comb begin
    for (int i = 0; i < 3; i++)
      uq[i] = dr.neg[i] ? UW'(-dr.quo[i]) : UW'(dr.quo[i]);
  end
  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= dr.vld;
    dout.unit_x      <= uq[0];
    dout.unit_y      <= uq[1];
    dout.unit_z      <= uq[2];
    dout.vec_length  <= dr.len;
    dout.zero_length <= dr.zero;
  end

`ifndef SYNTHESIS
  // a zero vector leaves a zero length and a zero unit_x
  a_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && dout.zero_length |-> dout.vec_length == '0 && dout.unit_x == '0)
    else $error("zero vector gave nonzero result");
  // unit_x magnitude never exceeds one
  a_range: assert property (@(posedge clk) disable iff (rst)
    dr.vld |-> dr.quo[0] <= QW'(1 << UNIT_FRAC_BITS))
    else $error("unit component out of range");
  // rounding stage valid follows root chain
  a_pipe: assert property (@(posedge clk) disable iff (rst)
    sr.vld |=> r_vld)
    else $error("transfer lost at rounding stage");
`endif

endmodule : vector3_normalize
`default_nettype wire

>>> hw/rtl/v3n_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_sqrt_cell: one digit step of the restoring square root
// Resolves one root bit per cell and passes the record on.
// ----------------------------------------------------------------------------
module v3n_sqrt_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire v3n_pkg::sqrt_rec_t cell_in,
  input  wire logic [5:0]         step,
  output v3n_pkg::sqrt_rec_t      cell_out
);
  import v3n_pkg::*;

  logic [SW-1:0] bitv;
  logic [SW-1:0] trial;
  sqrt_rec_t     rec_next;

  // bit = 4^(ROOT_STEPS-1-step); root held as running value, shifted
  always_comb begin
    rec_next = cell_in;
    bitv  = '0;
    bitv[2*(ROOT_STEPS-1-int'(step))] = 1'b1;
    trial = cell_in.root + bitv;
    if (cell_in.rem >= trial) begin
      rec_next.rem  = cell_in.rem - trial;
      rec_next.root = (cell_in.root >> 1) + bitv;
    end else begin
      rec_next.root = cell_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cell_out.vld <= 1'b0;
    else     cell_out.vld <= cell_in.vld;
    cell_out.rem  <= rec_next.rem;
    cell_out.root <= rec_next.root;
    cell_out.mag  <= rec_next.mag;
    cell_out.neg  <= rec_next.neg;
    cell_out.zero <= rec_next.zero;
  end
endmodule : v3n_sqrt_cell
`default_nettype wire

>>> hw/rtl/v3n_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_div_cell: one quotient bit of three restoring dividers
// Lanes share the rounded length as divisor.
// ----------------------------------------------------------------------------
module v3n_div_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire v3n_pkg::div_rec_t cell_in,
  input  wire logic [5:0]        step,
  output v3n_pkg::div_rec_t      cell_out
);
  import v3n_pkg::*;

  logic [NW:0] shifted [3];
  div_rec_t    rec_next;

  // shift in numerator bit NW-1-step, subtract divisor if it fits
  always_comb begin
    rec_next = cell_in;
    for (int i = 0; i < 3; i++) begin
      shifted[i] = {cell_in.rem[i], cell_in.num[i][NW-1-int'(step)]};
      if (shifted[i] >= (NW+1)'(cell_in.dvs)) begin
        rec_next.rem[i] = NW'(shifted[i] - (NW+1)'(cell_in.dvs));
        rec_next.quo[i] = {cell_in.quo[i][QW-2:0], 1'b1};
      end else begin
        rec_next.rem[i] = NW'(shifted[i]);
        rec_next.quo[i] = {cell_in.quo[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cell_out.vld <= 1'b0;
    else     cell_out.vld <= cell_in.vld;
    cell_out.dvs  <= rec_next.dvs;
    cell_out.rem  <= rec_next.rem;
    cell_out.num  <= rec_next.num;
    cell_out.quo  <= rec_next.quo;
    cell_out.neg  <= rec_next.neg;
    cell_out.len  <= rec_next.len;
    cell_out.zero <= rec_next.zero;
  end
endmodule : v3n_div_cell
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for vector3_normalize
// Drives directed and random Q8.8 vectors in bursts, predicts length and
// Q1.14 unit components in integer math, and checks every strobed transfer.
// ----------------------------------------------------------------------------
module testbench;
  import v3n_pkg::*;

  localparam int LATENCY  = 4 + ROOT_STEPS + DIV_STEPS;
  localparam int N_RANDOM = 1430;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  vec_in_t  din = '0;
  logic     strobe;
  vec_out_t dout;

  vec_in_t  pending_vecs[$];
  vec_out_t expected_units[$];
  int       errors = 0;
  bit       hold_for_drain = 1'b0;
  bit       feed_done = 1'b0;
  int       burst_left = 0;
  int       gap_left = 0;

  vector3_normalize uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .din(din), .strobe(strobe), .dout(dout)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // integer square root, floor
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // normalized vector for one input transfer
  function automatic vec_out_t normalize_vec(input vec_in_t v);
    longint unsigned mag[3];
    bit              neg[3];
    longint signed   comp[3];
    longint unsigned sum;
    longint unsigned root;
    longint unsigned len;
    longint unsigned dv;
    longint unsigned q[3];
    vec_out_t        r;
    comp[0] = v.vec_x;
    comp[1] = v.vec_y;
    comp[2] = v.vec_z;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i] < 0;
      mag[i] = neg[i] ? -comp[i] : comp[i];
      sum += mag[i] * mag[i];
    end
    root = isqrt(sum);
    len = (sum - root * root > root) ? root + 1 : root;
    dv = (len == 0) ? 1 : len;
    for (int i = 0; i < 3; i++) begin
      q[i] = ((mag[i] << UNIT_FRAC_BITS) + (dv >> 1)) / dv;
      if (neg[i]) q[i] = -q[i];
    end
    r.unit_x = q[0][UW-1:0];
    r.unit_y = q[1][UW-1:0];
    r.unit_z = q[2][UW-1:0];
    r.vec_length = len[CW-1:0];
    r.zero_length = (sum == 0);
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
      2: return $signed(16'($urandom_range(0, 1023))) - 16'sd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus
  initial begin
    vec_in_t v;
    logic signed [CW-1:0] corners[6];
    corners = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff, 16'sh0100};
    pending_vecs.push_back('0);
    for (int i = 0; i < 6; i++) begin
      v.vec_x = corners[i]; v.vec_y = '0; v.vec_z = '0; pending_vecs.push_back(v);
      v.vec_x = '0; v.vec_y = corners[i]; pending_vecs.push_back(v);
      v.vec_y = '0; v.vec_z = corners[i]; pending_vecs.push_back(v);
    end
    v = '{16'sh8000, 16'sh8000, 16'sh8000}; pending_vecs.push_back(v);
    v = '{16'sh7fff, 16'sh7fff, 16'sh7fff}; pending_vecs.push_back(v);
    v = '{16'sh7fff, 16'sh8000, 16'sh0001}; pending_vecs.push_back(v);
    v = '{16'sh0001, 16'sh0001, 16'sh0001}; pending_vecs.push_back(v);
    for (int i = 0; i < N_RANDOM; i++) begin
      v.vec_x = rand_comp();
      v.vec_y = rand_comp();
      v.vec_z = rand_comp();
      pending_vecs.push_back(v);
    end
    feed_done = 1'b1;
  end

  // reset and drain hold-off
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait (pending_vecs.size() < 700);
    @(posedge clk);
    hold_for_drain <= 1'b1;
    wait (expected_units.size() == 0);
    @(posedge clk);
    hold_for_drain <= 1'b0;
  end

  // driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) expected_units.push_back(normalize_vec(din));
      if (start && busy) begin
        // keep holding the same transfer
      end else if (hold_for_drain || pending_vecs.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        din <= pending_vecs.pop_front();
        start <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    vec_out_t e;
    if (!rst && strobe) begin
      if (expected_units.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = expected_units.pop_front();
        if (dout.unit_x !== e.unit_x) begin
          $error("unit_x expected %0d actual %0d", e.unit_x, dout.unit_x); errors++;
        end
        if (dout.unit_y !== e.unit_y) begin
          $error("unit_y expected %0d actual %0d", e.unit_y, dout.unit_y); errors++;
        end
        if (dout.unit_z !== e.unit_z) begin
          $error("unit_z expected %0d actual %0d", e.unit_z, dout.unit_z); errors++;
        end
        if (dout.vec_length !== e.vec_length) begin
          $error("vec_length expected %0d actual %0d", e.vec_length, dout.vec_length);
          errors++;
        end
        if (dout.zero_length !== e.zero_length) begin
          $error("zero_length expected %0d actual %0d", e.zero_length, dout.zero_length);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (feed_done);
    wait (pending_vecs.size() == 0 && !start && !rst);
    wait (expected_units.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // timeout
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/v3n_pkg.sv
hw/rtl/v3n_sqrt_cell.sv
hw/rtl/v3n_div_cell.sv
hw/rtl/vector3_normalize.sv
bench/testbench.sv
